>>> sv/touch_region_key_mapper_defines.svh
// ---------------------------------------------------------------------------
// Touch region key mapper: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TOUCH_REGION_KEY_MAPPER_DEFINES_SVH
`define TOUCH_REGION_KEY_MAPPER_DEFINES_SVH

// Same-cycle implication.
`define TRKM_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("trkm: same-cycle check failed");

// Next-cycle implication.
`define TRKM_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("trkm: next-cycle check failed");

`endif

>>> sv/trkm_pkg.sv
// ---------------------------------------------------------------------------
// Touch region key mapper package
// Region register layout, shape codes, reset values and key bit decode.
// ---------------------------------------------------------------------------
package trkm_pkg;

	localparam int CENTRE_BITS    = 11;
	localparam int RADIUS_BITS    = 7;
	localparam int KEY_IDX_BITS   = 4;
	localparam int KEY_BITS       = 16;
	localparam int MAX_REGIONS    = 8;
	localparam int CFG_INDEX_BITS = 3;
	localparam int REGION_BITS    = 42;

	typedef enum logic [1:0] {
		SHAPE_OFF    = 2'd0,
		SHAPE_CIRCLE = 2'd1,
		SHAPE_PILL   = 2'd2,
		SHAPE_PAD    = 2'd3
	} shape_t;

	typedef struct packed {
		logic [KEY_IDX_BITS-1:0] key;
		logic [RADIUS_BITS-1:0]  ry;
		logic [RADIUS_BITS-1:0]  rx;
		logic [CENTRE_BITS-1:0]  cy;
		logic [CENTRE_BITS-1:0]  cx;
		shape_t                  shape;
	} region_t;

	localparam logic [REGION_BITS-1:0] REGION_RESET [MAX_REGIONS] = '{
		42'd82246291113,
		42'd357124197689,
		42'd584824751926,
		42'd859702659278,
		42'd1154209448539,
		42'd2236503805394,
		42'd2511381709362,
		42'd0
	};

	// One-hot key bit for an index that may run past the top of the mask.
	function automatic logic [KEY_BITS-1:0] key_bit(input logic [KEY_IDX_BITS:0] idx);
		logic [KEY_BITS-1:0] bits;
		bits = '0;
		if (idx < (KEY_IDX_BITS+1)'(KEY_BITS)) begin
			bits[idx[KEY_IDX_BITS-1:0]] = 1'b1;
		end
		return bits;
	endfunction

endpackage

>>> sv/trkm_if.sv
// ---------------------------------------------------------------------------
// Touch region key mapper channels
// Valid/ready channels for touch points in and key masks out.
// ---------------------------------------------------------------------------
interface touch_point_if #(
	parameter int COORD_BITS = 11
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] touch_x;
	logic [COORD_BITS-1:0] touch_y;
	logic                  touch_down;
	logic                  last_point;

	modport source (output valid, touch_x, touch_y, touch_down, last_point, input ready);
	modport sink   (input valid, touch_x, touch_y, touch_down, last_point, output ready);
endinterface

interface key_mask_if;
	logic        valid;
	logic        ready;
	logic [15:0] key_mask;

	modport source (output valid, key_mask, input ready);
	modport sink   (input valid, key_mask, output ready);
endinterface

>>> sv/touch_region_key_mapper.sv
// ---------------------------------------------------------------------------
// Touch region key mapper
// Maps touch points onto a key mask through up to eight screen regions.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Payload                                   Handshake
//   touch    in         touch_x, touch_y, touch_down, last_point  valid/ready
//   keys     out        key_mask                                  valid/ready
//   cfg      in         cfg_index, cfg_wdata                      cfg_wr_en only
//
// One touch point enters per cycle while touch.ready is high. A point passes through
// an input stage where every region works out its offsets, squares and box
// compares in parallel, and a second stage where the circle sums are
// compared and the hits are merged into the pending mask. The key mask of a
// frame is registered at the edge where its last point leaves the second
// stage, and the word is offered from that output register.
// Reset clears the pending mask and the pipeline and loads the default
// regions. A stalled output word holds the second stage only when it carries
// a last point; other points keep flowing past it.

`include "touch_region_key_mapper_defines.svh"

module touch_region_key_mapper #(
	parameter int NUM_REGIONS = 7,
	parameter int COORD_BITS  = 11
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [trkm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [trkm_pkg::REGION_BITS-1:0]    cfg_wdata,
	touch_point_if.sink                         touch,
	key_mask_if.source                          keys
);
	import trkm_pkg::*;

	// Region registers. A write whose index matches no region is dropped.
	region_t region_q [NUM_REGIONS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGIONS; i++) begin
				region_q[i] <= region_t'(REGION_RESET[i]);
			end
		end else begin
			for (int i = 0; i < NUM_REGIONS; i++) begin
				if (cfg_wr_en && (cfg_index == CFG_INDEX_BITS'(i))) begin
					region_q[i] <= region_t'(cfg_wdata);
				end
			end
		end
	end

	// Pipeline flow control. The second stage only waits when it holds the
	// last point of a frame and the output word has not yet been taken.
	logic valid_s1, valid_s2, last_s2, out_valid_q;
	logic out_free, adv_s2, take_s2, adv_s1, out_load;

	logic [COORD_BITS-1:0] x_s1, y_s1;
	logic                  down_s1, last_s1;

	logic [KEY_BITS-1:0] pending_q, key_mask_q, hits, merged;
	logic [KEY_BITS-1:0] region_hit [NUM_REGIONS];

	always_comb begin
		out_free    = !out_valid_q || keys.ready;
		adv_s2      = valid_s2 && (!last_s2 || out_free);
		take_s2     = !valid_s2 || adv_s2;
		adv_s1      = valid_s1 && take_s2;
		touch.ready = !valid_s1 || adv_s1;
		out_load    = adv_s2 && last_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (touch.ready) begin
				valid_s1 <= touch.valid;
			end
			if (take_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (touch.valid && touch.ready) begin
			x_s1    <= touch.touch_x;
			y_s1    <= touch.touch_y;
			down_s1 <= touch.touch_down;
			last_s1 <= touch.last_point;
		end
		if (adv_s1) begin
			last_s2 <= last_s1;
		end
	end

	// One test unit per region; each holds its own second-stage registers.
	for (genvar g = 0; g < NUM_REGIONS; g++) begin : g_region
		trkm_region #(
			.COORD_BITS (COORD_BITS)
		) u_region (
			.clk        (clk),
			.load       (adv_s1),
			.touch_x    (x_s1),
			.touch_y    (y_s1),
			.touch_down (down_s1),
			.region     (region_q[g]),
			.hit_mask   (region_hit[g])
		);
	end

	always_comb begin
		hits = '0;
		for (int i = 0; i < NUM_REGIONS; i++) begin
			hits = hits | region_hit[i];
		end
		merged = pending_q | hits;
	end

	// The pending mask gathers hits across a frame and restarts after the
	// last point, whose own hits go out with the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s2) begin
				pending_q <= last_s2 ? '0 : merged;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (keys.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			key_mask_q <= merged;
		end
	end

	assign keys.valid    = out_valid_q;
	assign keys.key_mask = key_mask_q;

	// A word that is taken and not replaced leaves the output empty.
	`TRKM_ASSERT_NEXT(a_out_drains, keys.valid && keys.ready && !out_load, !keys.valid)
	// The frame's mask restarts from nothing once its last point has passed.
	`TRKM_ASSERT_NEXT(a_pending_clears, out_load, pending_q == '0)
	// Within a frame the pending mask only gains bits.
	`TRKM_ASSERT_NEXT(a_pending_grows, adv_s2 && !last_s2, (pending_q & $past(pending_q)) == $past(pending_q))

endmodule

>>> sv/trkm_region.sv
// ---------------------------------------------------------------------------
// Touch region key mapper: one region test
// Offsets and compares in the first stage, circle sum and compare in the second.
// ---------------------------------------------------------------------------
module trkm_region #(
	parameter int COORD_BITS = 11
) (
	input  logic                            clk,
	input  logic                            load,
	input  logic [COORD_BITS-1:0]           touch_x,
	input  logic [COORD_BITS-1:0]           touch_y,
	input  logic                            touch_down,
	input  trkm_pkg::region_t               region,
	output logic [trkm_pkg::KEY_BITS-1:0]   hit_mask
);
	import trkm_pkg::*;

	localparam int AW = (COORD_BITS > CENTRE_BITS) ? COORD_BITS : CENTRE_BITS;
	localparam int SW = 2 * AW;
	localparam int RW = 2 * RADIUS_BITS;

	logic [AW:0]           dx, dy;
	logic [AW-1:0]         ax, ay, rx_e, ry_e;
	logic                  box_xy, box_yx, dead;
	logic [KEY_IDX_BITS:0] pad_idx;
	logic [KEY_BITS-1:0]   mask_d, circ_bits_d;
	logic [SW-1:0]         sqx_d, sqy_d;
	logic [RW-1:0]         rr_d;

	logic [KEY_BITS-1:0]   mask_s2, circ_bits_s2;
	logic [SW-1:0]         sqx_s2, sqy_s2;
	logic [RW-1:0]         rr_s2;
	logic [SW:0]           dist_sq;

	always_comb begin
		dx   = (AW+1)'(touch_x) - (AW+1)'(region.cx);
		dy   = (AW+1)'(touch_y) - (AW+1)'(region.cy);
		ax   = dx[AW] ? AW'(-dx) : dx[AW-1:0];
		ay   = dy[AW] ? AW'(-dy) : dy[AW-1:0];
		rx_e = AW'(region.rx);
		ry_e = AW'(region.ry);

		box_xy = (ax <= rx_e) && (ay <= ry_e);
		box_yx = (ay <= rx_e) && (ax <= ry_e);
		dead   = (ax <= ry_e) && (ay <= ry_e);

		// Vertical arms win only on a strictly larger vertical offset.
		if (ay > ax) begin
			pad_idx = {1'b0, region.key} + (dy[AW] ? (KEY_IDX_BITS+1)'(2) : (KEY_IDX_BITS+1)'(3));
		end else begin
			pad_idx = {1'b0, region.key} + (dx[AW] ? (KEY_IDX_BITS+1)'(1) : (KEY_IDX_BITS+1)'(0));
		end

		sqx_d = SW'(ax) * SW'(ax);
		sqy_d = SW'(ay) * SW'(ay);
		rr_d  = RW'(region.rx) * RW'(region.rx);

		mask_d      = '0;
		circ_bits_d = '0;
		case (region.shape)
			SHAPE_CIRCLE: begin
				circ_bits_d = key_bit({1'b0, region.key});
			end
			SHAPE_PILL: begin
				if (box_xy) begin
					mask_d = key_bit({1'b0, region.key});
				end
			end
			SHAPE_PAD: begin
				if ((box_xy || box_yx) && !dead) begin
					mask_d = key_bit(pad_idx);
				end
			end
			default: begin
				mask_d = '0;
			end
		endcase

		if (!touch_down) begin
			mask_d      = '0;
			circ_bits_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mask_s2      <= mask_d;
			circ_bits_s2 <= circ_bits_d;
			sqx_s2       <= sqx_d;
			sqy_s2       <= sqy_d;
			rr_s2        <= rr_d;
		end
	end

	always_comb begin
		dist_sq  = (SW+1)'(sqx_s2) + (SW+1)'(sqy_s2);
		hit_mask = mask_s2 | ((dist_sq <= (SW+1)'(rr_s2)) ? circ_bits_s2 : '0);
	end

endmodule

>>> tb/sv/touch_region_key_mapper_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Touch region key mapper testbench
// Feeds touch points through the valid/ready channel, reprograms the seven
// regions between phases and checks every emitted key mask against an
// in-bench prediction of the region hit rules.
// ---------------------------------------------------------------------------
module touch_region_key_mapper_tb;

	import trkm_pkg::*;

	localparam int NUM_REGIONS   = 7;
	localparam int COORD_BITS    = 11;
	localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
	// Index one past the last region: writes to it must be ignored.
	localparam int SPARE_INDEX   = NUM_REGIONS;
	// The longest hold on the key side is HOLD_CYCLES; the watchdog limit is
	// several times that, so only a hung block can trip it.
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 2000;
	// Time for points still in the pipeline to leave it, with a little margin.
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 20;

	// Key bit offsets of the four pad arms from the pad's base index.
	localparam int ARM_RIGHT = 0;
	localparam int ARM_LEFT  = 1;
	localparam int ARM_UP    = 2;
	localparam int ARM_DOWN  = 3;

	// -----------------------------------------------------------------------
	// Prediction and checking of key masks.
	// The checker keeps its own copy of the regions and of the keys gathered
	// in the current frame. Each accepted point adds its hits; a last point
	// closes the frame and queues the mask that the block must emit.
	// -----------------------------------------------------------------------
	class key_mask_checker;
		region_t             regions [MAX_REGIONS];
		logic [KEY_BITS-1:0] frame_keys;
		logic [KEY_BITS-1:0] expected_masks [$];
		int unsigned         failures;

		function new();
			foreach (regions[i]) regions[i] = region_t'(REGION_RESET[i]);
			frame_keys = '0;
			failures   = 0;
		endfunction

		function void load_region(int unsigned index, logic [REGION_BITS-1:0] value);
			if (index < NUM_REGIONS) regions[index] = region_t'(value);
		endfunction

		// Bits past the top of the mask simply fall off.
		function logic [KEY_BITS-1:0] key_line(int idx);
			logic [KEY_BITS-1:0] bits;
			bits = '0;
			if (idx < KEY_BITS) bits[idx] = 1'b1;
			return bits;
		endfunction

		function logic [KEY_BITS-1:0] region_keys(region_t r, int x, int y);
			int dx, dy, ax, ay, rx, ry, base;
			dx   = x - int'(r.cx);
			dy   = y - int'(r.cy);
			ax   = (dx < 0) ? -dx : dx;
			ay   = (dy < 0) ? -dy : dy;
			rx   = int'(r.rx);
			ry   = int'(r.ry);
			base = int'(r.key);
			case (r.shape)
				SHAPE_CIRCLE: begin
					if (longint'(dx) * dx + longint'(dy) * dy <= longint'(rx) * rx)
						return key_line(base);
				end
				SHAPE_PILL: begin
					if (ax <= rx && ay <= ry) return key_line(base);
				end
				SHAPE_PAD: begin
					// Outside the cross, or inside the centre dead zone: no key.
					if (!((ax <= rx && ay <= ry) || (ay <= rx && ax <= ry))) return '0;
					if (ax <= ry && ay <= ry) return '0;
					// Vertical arms win only when strictly steeper; ties go sideways.
					if (ay > ax) return key_line(base + ((dy < 0) ? ARM_UP : ARM_DOWN));
					return key_line(base + ((dx < 0) ? ARM_LEFT : ARM_RIGHT));
				end
				default: ;
			endcase
			return '0;
		endfunction

		function void note_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
				logic down, logic last);
			if (down) begin
				for (int i = 0; i < NUM_REGIONS; i++)
					frame_keys |= region_keys(regions[i], int'(x), int'(y));
			end
			if (last) begin
				expected_masks.push_back(frame_keys);
				frame_keys = '0;
			end
		endfunction

		function void check_mask(logic [KEY_BITS-1:0] got);
			logic [KEY_BITS-1:0] want;
			if (expected_masks.size() == 0) begin
				$error("key_mask: expected none, actual %04h", got);
				failures++;
				return;
			end
			want = expected_masks.pop_front();
			if (got !== want) begin
				$error("key_mask: expected %04h, actual %04h", want, got);
				failures++;
			end
		endfunction

		function int unsigned waiting();
			return expected_masks.size();
		endfunction
	endclass

	// -----------------------------------------------------------------------
	// Clock, reset, channels and the block itself.
	// -----------------------------------------------------------------------
	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_wr_en;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [REGION_BITS-1:0]    cfg_wdata;

	touch_point_if #(.COORD_BITS(COORD_BITS)) touch_ch ();
	key_mask_if                               key_ch ();

	key_mask_checker mask_check;

	// Idling switches: the sender gaps between words, the receiver stalls.
	bit idle_on;
	bit stall_on;
	// Raised by the stimulus to ask the receiver for one long hold-off.
	bit hold_req;

	int unsigned quiet_cycles;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	touch_region_key_mapper #(
		.NUM_REGIONS (NUM_REGIONS),
		.COORD_BITS  (COORD_BITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.touch     (touch_ch.sink),
		.keys      (key_ch.source)
	);

	// -----------------------------------------------------------------------
	// Receiver. Ready is driven at rising edges. Random stalls while
	// stall_on is set, and one long hold-off on request so that the block
	// fills up and pushes back on the touch channel.
	// -----------------------------------------------------------------------
	initial begin
		key_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				key_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall_on && $urandom_range(0, 4) == 0) begin
				key_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 9)) @(posedge clk);
			end else begin
				key_ch.ready <= 1'b1;
			end
		end
	end

	// Inputs only change at rising edges, so the falling edge shows exactly
	// what the next rising edge will take. Output words are checked there,
	// and the watchdog counts cycles in which neither side moves a word.
	always @(negedge clk) begin
		if (arst_n) begin
			if (key_ch.valid && key_ch.ready) mask_check.check_mask(key_ch.key_mask);
			if ((touch_ch.valid && touch_ch.ready) || (key_ch.valid && key_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Stimulus helpers. Every task starts and ends in the time step of a
	// rising edge, so all drives are nonblocking and land cleanly.
	// -----------------------------------------------------------------------
	function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
		if (v < 0) return '0;
		if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
		return COORD_BITS'(v);
	endfunction

	function automatic logic [REGION_BITS-1:0] make_region(shape_t shape, int cx, int cy,
			int rx, int ry, int key);
		region_t r;
		r.shape = shape;
		r.cx    = CENTRE_BITS'(cx);
		r.cy    = CENTRE_BITS'(cy);
		r.rx    = RADIUS_BITS'(rx);
		r.ry    = RADIUS_BITS'(ry);
		r.key   = KEY_IDX_BITS'(key);
		return r;
	endfunction

	// Offers one word and waits for it to be taken. The checker hears of the
	// point at the falling edge before the edge that accepts it.
	task automatic send_point(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
			input logic down, input logic last);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			touch_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		touch_ch.valid      <= 1'b1;
		touch_ch.touch_x    <= x;
		touch_ch.touch_y    <= y;
		touch_ch.touch_down <= down;
		touch_ch.last_point <= last;
		@(negedge clk);
		while (!touch_ch.ready) @(negedge clk);
		mask_check.note_point(x, y, down, last);
		@(posedge clk);
	endtask

	// A point placed relative to the centre of region i as currently set.
	task automatic send_offset(input int i, input int ox, input int oy,
			input logic down, input logic last);
		region_t r;
		r = mask_check.regions[i];
		send_point(clamp_coord(int'(r.cx) + ox), clamp_coord(int'(r.cy) + oy), down, last);
	endtask

	// A point somewhere around a random region, straddling its edges.
	task automatic pick_near(output logic [COORD_BITS-1:0] x, output logic [COORD_BITS-1:0] y);
		region_t r;
		int      span;
		r    = mask_check.regions[$urandom_range(0, NUM_REGIONS - 1)];
		span = ((r.rx > r.ry) ? int'(r.rx) : int'(r.ry)) + 4;
		x    = clamp_coord(int'(r.cx) + int'($urandom_range(0, 2 * span)) - span);
		y    = clamp_coord(int'(r.cy) + int'($urandom_range(0, 2 * span)) - span);
	endtask

	// Lowers valid and waits for every queued key mask, then gives the block
	// time to finish non-last points that produce nothing visible.
	task automatic settle();
		touch_ch.valid <= 1'b0;
		while (mask_check.waiting() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all regions in order, then pokes the unused index, which the
	// block must ignore. Write enable only drops after the last write.
	task automatic write_regions(input logic [REGION_BITS-1:0] values [NUM_REGIONS]);
		logic [REGION_BITS-1:0] junk;
		for (int i = 0; i < NUM_REGIONS; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_INDEX_BITS'(i);
			cfg_wdata <= values[i];
			@(posedge clk);
			mask_check.load_region(i, values[i]);
		end
		if (SPARE_INDEX < MAX_REGIONS) begin
			junk      = REGION_BITS'({$urandom, $urandom});
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_INDEX_BITS'(SPARE_INDEX);
			cfg_wdata <= junk;
			@(posedge clk);
			mask_check.load_region(SPARE_INDEX, junk);
		end
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_regions();
		logic [REGION_BITS-1:0] values [NUM_REGIONS];
		foreach (values[i]) values[i] = REGION_BITS'({$urandom, $urandom});
		write_regions(values);
	endtask

	// Mostly well-formed frames of one to six points around the regions.
	// A few frames are empty, a few are scattered over the whole screen and
	// a few run on without a last point into the next frame.
	task automatic random_frames(input int budget);
		int                    sent, points, kind, p;
		logic [COORD_BITS-1:0] x, y;
		sent = 0;
		while (sent < budget) begin
			points = $urandom_range(1, 6);
			kind   = $urandom_range(0, 19);
			if (kind == 0) begin
				send_point(COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b0, 1'b1);
				sent++;
			end else begin
				for (p = 0; p < points; p++) begin
					if (kind == 1 || $urandom_range(0, 9) == 0) begin
						x = COORD_BITS'($urandom);
						y = COORD_BITS'($urandom);
					end else begin
						pick_near(x, y);
					end
					send_point(x, y, $urandom_range(0, 7) != 0, (p == points - 1) && kind != 2);
					sent++;
				end
			end
		end
	endtask

	// -----------------------------------------------------------------------
	// Test sequence.
	// -----------------------------------------------------------------------
	initial begin
		logic [REGION_BITS-1:0] extremes [NUM_REGIONS];
		int                     arm;

		mask_check          = new();
		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_index           = '0;
		cfg_wdata           = '0;
		touch_ch.valid      = 1'b0;
		touch_ch.touch_x    = '0;
		touch_ch.touch_y    = '0;
		touch_ch.touch_down = 1'b0;
		touch_ch.last_point = 1'b0;
		idle_on             = 1'b1;
		stall_on            = 1'b1;
		hold_req            = 1'b0;
		quiet_cycles        = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset regions. Each region's centre on its own frame: circles and
		// pills hit, the pad centre sits in its dead zone and gives nothing.
		for (int i = 0; i < NUM_REGIONS; i++) send_offset(i, 0, 0, 1'b1, 1'b1);
		// The four pad arms at full reach, then one pixel beyond the right arm.
		arm = int'(mask_check.regions[4].rx);
		send_offset(4, arm, 0, 1'b1, 1'b1);
		send_offset(4, -arm, 0, 1'b1, 1'b1);
		send_offset(4, 0, -arm, 1'b1, 1'b1);
		send_offset(4, 0, arm, 1'b1, 1'b1);
		send_offset(4, arm + 1, 0, 1'b1, 1'b1);
		// Screen corners as one frame.
		send_point('0, '0, 1'b1, 1'b0);
		send_point(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), 1'b1, 1'b1);
		// A released point over a key adds nothing; then an empty frame.
		send_offset(0, 0, 0, 1'b0, 1'b0);
		send_point('0, '0, 1'b0, 1'b1);
		// Several keys gathered over one frame.
		send_offset(0, 0, 0, 1'b1, 1'b0);
		send_offset(1, 0, 0, 1'b1, 1'b0);
		send_offset(5, 0, 0, 1'b1, 1'b1);

		// Extreme settings: every shape at the screen edges, radii at their
		// limits and pad bases high enough that some arms run off the mask.
		settle();
		extremes[0] = make_region(SHAPE_PAD, COORD_MAX, COORD_MAX, 127, 127, 14);
		extremes[1] = '0;
		extremes[2] = make_region(SHAPE_PILL, 0, 0, 127, 127, 0);
		extremes[3] = make_region(SHAPE_CIRCLE, COORD_MAX, 0, 127, 0, 15);
		extremes[4] = make_region(SHAPE_PAD, 1024, 1024, 127, 0, 13);
		extremes[5] = make_region(SHAPE_CIRCLE, 0, COORD_MAX, 0, 0, 7);
		extremes[6] = '1;
		write_regions(extremes);
		send_point(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), 1'b1, 1'b1);
		send_point('0, '0, 1'b1, 1'b1);
		send_point(COORD_BITS'(COORD_MAX), '0, 1'b1, 1'b1);
		send_point('0, COORD_BITS'(COORD_MAX), 1'b1, 1'b1);
		// Pad with a single-pixel dead zone and a base of 13: the up arm is
		// the top bit, the down arm falls off the mask.
		send_offset(4, 127, 0, 1'b1, 1'b1);
		send_offset(4, -127, 0, 1'b1, 1'b1);
		send_offset(4, 0, -127, 1'b1, 1'b1);
		send_offset(4, 0, 127, 1'b1, 1'b1);
		send_offset(4, 1, 0, 1'b1, 1'b1);
		send_offset(4, 0, 0, 1'b1, 1'b1);
		random_frames(120);

		// Random region sets, with idling switched per phase. In the second
		// one the receiver holds off while single-point frames keep coming.
		for (int phase = 0; phase < 3; phase++) begin
			settle();
			random_regions();
			idle_on  = $urandom_range(0, 3) != 0;
			stall_on = $urandom_range(0, 3) != 0;
			if (phase == 1) begin
				hold_req = 1'b1;
				for (int k = 0; k < 30; k++) begin
					logic [COORD_BITS-1:0] hx, hy;
					pick_near(hx, hy);
					send_point(hx, hy, 1'b1, 1'b1);
				end
			end
			random_frames(90);
		end

		// Last stretch at full rate on both sides.
		settle();
		random_regions();
		idle_on  = 1'b0;
		stall_on = 1'b0;
		random_frames(80);

		touch_ch.valid <= 1'b0;
		while (mask_check.waiting() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mask_check.failures == 0 && mask_check.waiting() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
